// File: design/ppsp_pkg.sv
// Shared types and constants for the PPM P6 stream parser.
// No dependencies; imported by every module of the block.
package ppsp_pkg;

    localparam int DEFAULT_DIM_BITS    = 16;
    localparam int DEFAULT_TOKEN_LIMIT = 64;

    localparam int PIXEL_W = 24;
    localparam int SIZE_W  = 16;

    typedef enum logic [2:0] {
        PH_MAGIC0     = 3'd0,
        PH_MAGIC1     = 3'd1,
        PH_MAGIC_REST = 3'd2,
        PH_WIDTH      = 3'd3,
        PH_HEIGHT     = 3'd4,
        PH_MAXVAL     = 3'd5,
        PH_PIXELS     = 3'd6,
        PH_DONE       = 3'd7
    } ppsp_phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } ppsp_kind_t;

    typedef enum logic [2:0] {
        ERR_MAGIC     = 3'd0,
        ERR_EARLY_END = 3'd1,
        ERR_WIDTH     = 3'd2,
        ERR_HEIGHT    = 3'd3,
        ERR_MAXVAL    = 3'd4,
        ERR_TRUNCATED = 3'd5
    } ppsp_err_t;

    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_SIX  = 8'h36;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam int         MAXVAL_OK = 255;

    typedef struct packed {
        ppsp_kind_t         kind;
        logic [PIXEL_W-1:0] pixel;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        ppsp_err_t          code;
        logic               last;
        logic               big;
    } ppsp_result_t;

endpackage

// File: design/ppsp_parser.sv
// Parser state registers and the per-byte update logic.
// Depends on ppsp_pkg for phase, kind, error and result types.
module ppsp_parser import ppsp_pkg::*; #(
    parameter int DIM_BITS    = DEFAULT_DIM_BITS,
    parameter int TOKEN_LIMIT = DEFAULT_TOKEN_LIMIT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         step_en,
    input  logic [7:0]   data_byte,
    input  logic         end_of_stream,
    output logic         res_valid,
    output ppsp_result_t res
);

    localparam int LEN_W = $clog2(TOKEN_LIMIT);
    localparam int ACC_W = DIM_BITS + 1;
    localparam int MUL_W = ACC_W + 4;
    localparam int PIX_W = 2 * DIM_BITS;
    localparam int EXT_W = (DIM_BITS > SIZE_W) ? DIM_BITS : SIZE_W;

    localparam logic [LEN_W-1:0] LEN_LAST  = LEN_W'(TOKEN_LIMIT - 1);
    localparam logic [LEN_W-1:0] LEN_MAGIC = LEN_W'(2);
    localparam logic [MUL_W-1:0] DIM_MAX_W = (MUL_W'(1) << DIM_BITS) - MUL_W'(1);
    localparam logic [ACC_W-1:0] ACC_SAT   = {1'b1, {DIM_BITS{1'b0}}};
    localparam logic [ACC_W-1:0] ACC_MAXV  = ACC_W'(MAXVAL_OK);

    typedef struct packed {
        ppsp_phase_t         phase;
        logic                in_comment;
        logic                comment_tail;
        logic [LEN_W-1:0]    tlen;
        logic                tbad;
        logic                dstop;
        logic [ACC_W-1:0]    acc;
        logic [DIM_BITS-1:0] wid;
        logic [DIM_BITS-1:0] hgt;
        logic [PIX_W-1:0]    pleft;
        logic [1:0]          chan;
        logic [15:0]         held;
    } pst_t;

    typedef struct packed {
        pst_t         st;
        logic         have;
        ppsp_result_t res;
    } fin_t;

    pst_t         state_reg, state_next;
    logic         order_reg;
    logic [PIX_W-1:0] area;
    fin_t         stp;

    function automatic logic [SIZE_W-1:0] to_size(logic [DIM_BITS-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[SIZE_W-1:0];
    endfunction

    function automatic pst_t clear_tok(pst_t s);
        pst_t t;
        t = s;
        t.in_comment   = 1'b0;
        t.comment_tail = 1'b0;
        t.tlen         = '0;
        t.tbad         = 1'b0;
        t.dstop        = 1'b0;
        t.acc          = '0;
        return t;
    endfunction

    function automatic fin_t fail_f(fin_t f, ppsp_err_t code, logic big);
        fin_t g;
        g = f;
        g.have     = 1'b1;
        g.res      = '0;
        g.res.kind = KIND_ERROR;
        g.res.code = code;
        g.res.big  = big;
        g.st.phase = PH_DONE;
        return g;
    endfunction

    function automatic logic in_header(ppsp_phase_t p);
        return p == PH_MAGIC_REST || p == PH_WIDTH || p == PH_HEIGHT || p == PH_MAXVAL;
    endfunction

    // Close the open token and act on it for the current header field.
    function automatic fin_t finish_f(fin_t f, logic [PIX_W-1:0] prod);
        fin_t             g;
        logic [LEN_W-1:0] len;
        logic             bad;
        logic [ACC_W-1:0] val;
        ppsp_err_t        code;
        g    = f;
        len  = f.st.tlen;
        bad  = f.st.tbad;
        val  = f.st.acc;
        code = (f.st.phase == PH_WIDTH) ? ERR_WIDTH : ERR_HEIGHT;
        g.st = clear_tok(f.st);
        case (f.st.phase) inside
            PH_MAGIC_REST: g.st.phase = PH_WIDTH;
            PH_WIDTH, PH_HEIGHT: begin
                if (len == '0) begin
                    g = fail_f(g, ERR_EARLY_END, 1'b0);
                end else if (bad) begin
                    g = fail_f(g, code, 1'b0);
                end else if (val[DIM_BITS]) begin
                    g = fail_f(g, code, 1'b1);
                end else if (f.st.phase == PH_WIDTH) begin
                    g.st.wid   = val[DIM_BITS-1:0];
                    g.st.phase = PH_HEIGHT;
                end else begin
                    g.st.hgt   = val[DIM_BITS-1:0];
                    g.st.phase = PH_MAXVAL;
                end
            end
            PH_MAXVAL: begin
                if (len == '0) begin
                    g = fail_f(g, ERR_EARLY_END, 1'b0);
                end else if (bad || val != ACC_MAXV) begin
                    g = fail_f(g, ERR_MAXVAL, 1'b0);
                end else begin
                    g.have       = 1'b1;
                    g.res        = '0;
                    g.res.kind   = KIND_HEADER;
                    g.res.width  = to_size(f.st.wid);
                    g.res.height = to_size(f.st.hgt);
                    g.st.pleft   = prod;
                    g.st.chan    = 2'd0;
                    g.st.held    = '0;
                    g.st.phase   = (prod == '0) ? PH_DONE : PH_PIXELS;
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // Width and height are settled by the time maxval closes.
    assign area = PIX_W'(state_reg.wid) * PIX_W'(state_reg.hgt);

    // Next-state logic: one byte's worth of parsing.
    always_comb begin
        logic             nl;
        logic             ws;
        logic             skip;
        logic [MUL_W-1:0] v;
        logic [7:0]       r;
        logic [7:0]       g;
        stp.st   = state_reg;
        stp.have = 1'b0;
        stp.res  = '0;
        nl   = data_byte == CHAR_LF || data_byte == CHAR_CR;
        ws   = data_byte == CHAR_SP || (data_byte >= CHAR_TAB && data_byte <= CHAR_CR);
        skip = 1'b0;
        v    = (MUL_W'(state_reg.acc) << 3) + (MUL_W'(state_reg.acc) << 1)
             + MUL_W'(data_byte[3:0]);
        r    = state_reg.held[7:0];
        g    = state_reg.held[15:8];

        case (state_reg.phase) inside
            PH_MAGIC0: begin
                if (data_byte == CHAR_P) stp.st.phase = PH_MAGIC1;
                else stp = fail_f(stp, ERR_MAGIC, 1'b0);
            end
            PH_MAGIC1: begin
                if (data_byte == CHAR_SIX) begin
                    stp.st       = clear_tok(stp.st);
                    stp.st.phase = PH_MAGIC_REST;
                    stp.st.tlen  = LEN_MAGIC;
                end else begin
                    stp = fail_f(stp, ERR_MAGIC, 1'b0);
                end
            end
            PH_MAGIC_REST, PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                if (state_reg.in_comment) begin
                    if (nl) begin
                        stp.st.in_comment   = 1'b0;
                        stp.st.comment_tail = 1'b1;
                    end
                end else begin
                    // drop one CR or LF right after a comment's line end
                    if (state_reg.comment_tail) begin
                        stp.st.comment_tail = 1'b0;
                        skip = nl;
                    end
                    if (!skip) begin
                        if (state_reg.tlen >= LEN_LAST) begin
                            stp = finish_f(stp, area);
                        end else if (ws) begin
                            if (state_reg.tlen != '0) stp = finish_f(stp, area);
                        end else if (data_byte == CHAR_HASH) begin
                            stp.st.in_comment = 1'b1;
                        end else begin
                            if (data_byte >= CHAR_ZERO && data_byte <= CHAR_NINE) begin
                                if (!state_reg.dstop) begin
                                    stp.st.acc = (v > DIM_MAX_W) ? ACC_SAT : v[ACC_W-1:0];
                                end
                            end else begin
                                if (state_reg.tlen == '0) stp.st.tbad = 1'b1;
                                stp.st.dstop = 1'b1;
                            end
                            stp.st.tlen = state_reg.tlen + LEN_W'(1);
                        end
                    end
                end
            end
            PH_PIXELS: begin
                case (state_reg.chan)
                    2'd0: begin
                        stp.st.held = {8'h00, data_byte};
                        stp.st.chan = 2'd1;
                    end
                    2'd1: begin
                        stp.st.held[15:8] = data_byte;
                        stp.st.chan       = 2'd2;
                    end
                    default: begin
                        stp.st.chan  = 2'd0;
                        stp.st.pleft = state_reg.pleft - PIX_W'(1);
                        stp.have     = 1'b1;
                        stp.res      = '0;
                        stp.res.kind = KIND_PIXEL;
                        stp.res.pixel = order_reg ? {data_byte, g, r} : {r, g, data_byte};
                        stp.res.last  = stp.st.pleft == '0;
                        if (stp.st.pleft == '0) stp.st.phase = PH_DONE;
                    end
                endcase
            end
            default: ;
        endcase

        if (end_of_stream) begin
            if (stp.st.phase == PH_MAGIC0 || stp.st.phase == PH_MAGIC1) begin
                stp = fail_f(stp, ERR_MAGIC, 1'b0);
            end else if (in_header(stp.st.phase)) begin
                stp = finish_f(stp, area);
                if (in_header(stp.st.phase)) stp = fail_f(stp, ERR_EARLY_END, 1'b0);
            end
            if (stp.st.phase == PH_PIXELS) stp = fail_f(stp, ERR_TRUNCATED, 1'b0);
            stp.st       = '0;
            stp.st.phase = PH_MAGIC0;
        end
    end

    // Output logic: hand the step's state and result on.
    always_comb begin
        state_next = state_reg;
        res_valid  = 1'b0;
        res        = stp.res;
        if (step_en) begin
            state_next = stp.st;
            res_valid  = stp.have;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= '0;
            state_reg.phase <= PH_MAGIC0;
            order_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) order_reg <= cfg_wr_data;
        end
    end

endmodule

// File: design/ppsp_result_reg.sv
// Result register between the parser and the output channel.
// Depends on ppsp_pkg for the result type.
module ppsp_result_reg import ppsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  ppsp_result_t load_data,
    output logic         free,
    output logic         m_valid,
    input  logic         m_ready,
    output ppsp_result_t m_data
);

    logic         valid_reg;
    ppsp_result_t data_reg;

    // a new beat may enter while the held one leaves
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) data_reg <= load_data;
    end

endmodule

// File: design/ppm_p6_stream_parser.sv
// PPM P6 stream parser: takes one file byte per beat and returns a header beat
// (width, height), one pixel beat per RGB triple, or one error beat. Bytes are
// accepted back to back as long as the result register is empty or drained in
// the same cycle, so a pixel beat leaves every third byte.
// Depends on ppsp_pkg, ppsp_parser and ppsp_result_reg.
module ppm_p6_stream_parser import ppsp_pkg::*; #(
    parameter int DIM_BITS    = DEFAULT_DIM_BITS,
    parameter int TOKEN_LIMIT = DEFAULT_TOKEN_LIMIT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_end_of_stream,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [PIXEL_W-1:0]  m_pixel,
    output logic [SIZE_W-1:0]   m_image_width,
    output logic [SIZE_W-1:0]   m_image_height,
    output logic [2:0]          m_error_code,
    output logic                m_last_pixel,
    output logic                m_size_too_large
);

    logic         step_en;
    logic         res_valid;
    ppsp_result_t res;
    ppsp_result_t out_data;

    assign step_en = s_valid && s_ready;

    ppsp_parser #(
        .DIM_BITS    (DIM_BITS),
        .TOKEN_LIMIT (TOKEN_LIMIT)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .step_en       (step_en),
        .data_byte     (s_data_byte),
        .end_of_stream (s_end_of_stream),
        .res_valid     (res_valid),
        .res           (res)
    );

    ppsp_result_reg u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .free      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_kind           = out_data.kind;
    assign m_pixel          = out_data.pixel;
    assign m_image_width    = out_data.width;
    assign m_image_height   = out_data.height;
    assign m_error_code     = out_data.code;
    assign m_last_pixel     = out_data.last;
    assign m_size_too_large = out_data.big;

endmodule

// File: sim/tb_ppm_p6_stream_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for ppm_p6_stream_parser: feeds P6 files byte by byte and
// compares each result beat with an in-bench model of the parser.
// Depends on ppsp_pkg and the parser RTL.
module tb_ppm_p6_stream_parser;
    import ppsp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int DIM_BITS     = DEFAULT_DIM_BITS;
    localparam int TOKEN_LIMIT  = DEFAULT_TOKEN_LIMIT;
    localparam int DIM_MAX      = (1 << DIM_BITS) - 1;
    localparam int DRAIN_CYCLES = 12;
    // ~1850 bytes in all; the watchdog stops the run at this cycle limit
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } stream_byte_t;

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_wr_en       = 1'b0;
    logic                cfg_wr_data     = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte     = 8'h00;
    logic                s_end_of_stream = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [1:0]          m_kind;
    logic [PIXEL_W-1:0]  m_pixel;
    logic [SIZE_W-1:0]   m_image_width;
    logic [SIZE_W-1:0]   m_image_height;
    logic [2:0]          m_error_code;
    logic                m_last_pixel;
    logic                m_size_too_large;

    ppm_p6_stream_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_stream  (s_end_of_stream),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_pixel          (m_pixel),
        .m_image_width    (m_image_width),
        .m_image_height   (m_image_height),
        .m_error_code     (m_error_code),
        .m_last_pixel     (m_last_pixel),
        .m_size_too_large (m_size_too_large)
    );

    always #CLK_HALF aclk = ~aclk;

    stream_byte_t  byte_backlog[$];
    ppsp_result_t  expected_beats[$];
    logic [7:0]    staging[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  bytes_queued  = 0;
    int  bytes_taken   = 0;
    int  files_taken   = 0;
    int  pixels_seen   = 0;
    int  headers_seen  = 0;
    int  errors_seen   = 0;
    logic [7:0] err_codes_seen = 8'h00;

    // ---------------------------------------------------------------- parser model
    logic            rgb_swap;
    ppsp_phase_t     parse_ph;
    logic            cmt_open, cmt_tail, tok_bad, tok_digits_done;
    int unsigned     tok_len, tok_value;
    logic [15:0]     img_width, img_height;
    longint unsigned pixels_owed;
    logic [1:0]      chan_slot;
    logic [15:0]     chan_held;
    bit              beat_due;
    ppsp_result_t    beat_pred;

    function automatic void clear_token();
        cmt_open = 1'b0;
        cmt_tail = 1'b0;
        tok_len = 0;
        tok_bad = 1'b0;
        tok_digits_done = 1'b0;
        tok_value = 0;
    endfunction

    function automatic void clear_parser();
        parse_ph = PH_MAGIC0;
        clear_token();
        img_width = '0;
        img_height = '0;
        pixels_owed = 0;
        chan_slot = 2'd0;
        chan_held = '0;
    endfunction

    function automatic void new_beat(ppsp_kind_t k);
        beat_due = 1'b1;
        beat_pred = '0;
        beat_pred.kind = k;
    endfunction

    function automatic void flag_error(ppsp_err_t code, logic big);
        new_beat(KIND_ERROR);
        beat_pred.code = code;
        beat_pred.big = big;
        parse_ph = PH_DONE;
    endfunction

    function automatic void start_image();
        new_beat(KIND_HEADER);
        beat_pred.width = img_width;
        beat_pred.height = img_height;
        pixels_owed = img_width;
        pixels_owed = pixels_owed * img_height;
        chan_slot = 2'd0;
        chan_held = '0;
        if (pixels_owed == 0) parse_ph = PH_DONE;
        else parse_ph = PH_PIXELS;
    endfunction

    function automatic void end_token();
        int unsigned len, val;
        logic        bad;
        ppsp_err_t   code;
        len = tok_len;
        bad = tok_bad;
        val = tok_value;
        clear_token();
        case (parse_ph)
            PH_MAGIC_REST: parse_ph = PH_WIDTH;
            PH_WIDTH, PH_HEIGHT: begin
                if (parse_ph == PH_WIDTH) code = ERR_WIDTH;
                else code = ERR_HEIGHT;
                if (len == 0) flag_error(ERR_EARLY_END, 1'b0);
                else if (bad) flag_error(code, 1'b0);
                else if (val > DIM_MAX) flag_error(code, 1'b1);
                else if (parse_ph == PH_WIDTH) begin
                    img_width = val[15:0];
                    parse_ph = PH_HEIGHT;
                end else begin
                    img_height = val[15:0];
                    parse_ph = PH_MAXVAL;
                end
            end
            PH_MAXVAL: begin
                if (len == 0) flag_error(ERR_EARLY_END, 1'b0);
                else if (bad || val != MAXVAL_OK) flag_error(ERR_MAXVAL, 1'b0);
                else start_image();
            end
            default: ;
        endcase
    endfunction

    function automatic void scan_token_byte(logic [7:0] b);
        logic        nl;
        int unsigned v;
        nl = (b == CHAR_LF || b == CHAR_CR);
        if (cmt_open) begin
            if (nl) begin
                cmt_open = 1'b0;
                cmt_tail = 1'b1;
            end
            return;
        end
        // one CR or LF right after the comment's line end is swallowed
        if (cmt_tail) begin
            cmt_tail = 1'b0;
            if (nl) return;
        end
        if (tok_len >= TOKEN_LIMIT - 1) begin
            end_token();
            return;
        end
        if (b == CHAR_SP || (b >= CHAR_TAB && b <= CHAR_CR)) begin
            if (tok_len != 0) end_token();
            return;
        end
        if (b == CHAR_HASH) begin
            cmt_open = 1'b1;
            return;
        end
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            if (!tok_digits_done) begin
                v = tok_value * 10 + (b - CHAR_ZERO);
                tok_value = (v > DIM_MAX) ? DIM_MAX + 1 : v;
            end
        end else begin
            if (tok_len == 0) tok_bad = 1'b1;
            tok_digits_done = 1'b1;
        end
        tok_len++;
    endfunction

    function automatic void take_pixel_byte(logic [7:0] b);
        logic [23:0] rgb;
        if (chan_slot == 2'd0) begin
            chan_held = {8'h00, b};
            chan_slot = 2'd1;
            return;
        end
        if (chan_slot == 2'd1) begin
            chan_held[15:8] = b;
            chan_slot = 2'd2;
            return;
        end
        chan_slot = 2'd0;
        rgb = rgb_swap ? {b, chan_held[15:8], chan_held[7:0]}
                       : {chan_held[7:0], chan_held[15:8], b};
        pixels_owed = pixels_owed - 1;
        new_beat(KIND_PIXEL);
        beat_pred.pixel = rgb;
        beat_pred.last = (pixels_owed == 0);
        if (pixels_owed == 0) parse_ph = PH_DONE;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eos);
        beat_due = 1'b0;
        case (parse_ph)
            PH_MAGIC0: begin
                if (b == CHAR_P) parse_ph = PH_MAGIC1;
                else flag_error(ERR_MAGIC, 1'b0);
            end
            PH_MAGIC1: begin
                if (b == CHAR_SIX) begin
                    parse_ph = PH_MAGIC_REST;
                    clear_token();
                    tok_len = 2;
                end else begin
                    flag_error(ERR_MAGIC, 1'b0);
                end
            end
            PH_MAGIC_REST, PH_WIDTH, PH_HEIGHT, PH_MAXVAL: scan_token_byte(b);
            PH_PIXELS: take_pixel_byte(b);
            default: ;
        endcase
        if (eos) begin
            if (parse_ph == PH_MAGIC0 || parse_ph == PH_MAGIC1) begin
                flag_error(ERR_MAGIC, 1'b0);
            end else if (parse_ph >= PH_MAGIC_REST && parse_ph <= PH_MAXVAL) begin
                // the open token is judged first; its error wins
                end_token();
                if (parse_ph >= PH_MAGIC_REST && parse_ph <= PH_MAXVAL)
                    flag_error(ERR_EARLY_END, 1'b0);
            end
            if (parse_ph == PH_PIXELS) flag_error(ERR_TRUNCATED, 1'b0);
            clear_parser();
        end
    endfunction

    // ---------------------------------------------------------------- driver
    always @(posedge aclk) begin : byte_driver
        stream_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_data_byte, s_end_of_stream);
                if (beat_due) expected_beats.push_back(beat_pred);
                bytes_taken++;
                if (s_end_of_stream) files_taken++;
            end
            // hold the beat while it is stalled
            if (!s_valid || s_ready) begin
                if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = byte_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= nxt.data;
                    s_end_of_stream <= nxt.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        ppsp_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d", m_kind);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("pixel", want.pixel, m_pixel);
                    check_field("image_width", want.width, m_image_width);
                    check_field("image_height", want.height, m_image_height);
                    check_field("error_code", want.code, m_error_code);
                    check_field("last_pixel", want.last, m_last_pixel);
                    check_field("size_too_large", want.big, m_size_too_large);
                    if (want.kind == KIND_PIXEL) pixels_seen++;
                    else if (want.kind == KIND_HEADER) headers_seen++;
                    else begin
                        errors_seen++;
                        err_codes_seen[want.code] = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d beats still expected",
                   cycle_count, expected_beats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_byte(logic [7:0] b);
        staging.push_back(b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) staging.push_back(s[i]);
    endtask

    task automatic push_file();
        stream_byte_t e;
        for (int i = 0; i < staging.size(); i++) begin
            e.data = staging[i];
            e.eos = (i == staging.size() - 1);
            byte_backlog.push_back(e);
        end
        bytes_queued += staging.size();
        staging.delete();
    endtask

    task automatic send_text(string s);
        add_text(s);
        push_file();
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 5))
            0: return CHAR_SP;
            1: return CHAR_TAB;
            2: return CHAR_LF;
            3: return CHAR_CR;
            4: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    task automatic add_gap();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) add_byte(any_blank());
        if ($urandom_range(0, 4) == 0) begin
            add_byte(CHAR_HASH);
            repeat ($urandom_range(0, 6)) begin
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_LF || b == CHAR_CR) b = CHAR_SP;
                add_byte(b);
            end
            add_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
            if ($urandom_range(0, 1)) add_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
        end
    endtask

    task automatic add_number(int unsigned v);
        if ($urandom_range(0, 9) == 0) add_byte(CHAR_ZERO);
        add_text($sformatf("%0d", v));
        // letters after the digits end the value but not the token
        if ($urandom_range(0, 9) == 0) add_byte(8'(8'h61 + $urandom_range(0, 25)));
    endtask

    task automatic build_image_file();
        int unsigned w, h, maxv, sel, cut, idx;
        add_text("P6");
        sel = $urandom_range(0, 99);
        if (sel < 3)
            repeat ($urandom_range(61, 66)) add_byte(8'(8'h41 + $urandom_range(0, 25)));
        else if (sel < 30)
            repeat ($urandom_range(1, 3)) add_byte(8'(8'h41 + $urandom_range(0, 25)));
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 4);
        end else if (sel < 87) begin
            w = $urandom_range(0, DIM_MAX);
            h = 0;
        end else if (sel < 94) begin
            w = $urandom_range(1, 4);
            h = $urandom_range(DIM_MAX + 1, 999999);
        end else begin
            w = DIM_MAX;
            h = 0;
        end
        if ($urandom_range(0, 1)) begin
            cut = w;
            w = h;
            h = cut;
        end
        maxv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : MAXVAL_OK;
        add_gap();
        add_number(w);
        add_gap();
        add_number(h);
        add_gap();
        add_number(maxv);
        add_byte(any_blank());
        if (sel < 80) repeat (3 * w * h) add_byte(8'($urandom_range(0, 255)));
        // break some files: cut short, flip a byte, or trail junk
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            cut = $urandom_range(1, staging.size() - 1);
            while (staging.size() > cut) staging.delete(staging.size() - 1);
        end else if (sel < 16) begin
            idx = $urandom_range(0, staging.size() - 1);
            staging[idx] = 8'($urandom_range(0, 255));
        end else if (sel < 22) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        push_file();
    endtask

    task automatic queue_random_files(int n);
        int target;
        target = bytes_queued + n;
        while (bytes_queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) add_text("P6");
                repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
                push_file();
            end else begin
                build_image_file();
            end
        end
    endtask

    task automatic settle();
        while (byte_backlog.size() != 0 || s_valid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_order(logic v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rgb_swap = v;
    endtask

    initial begin : stimulus
        rgb_swap = 1'b0;
        clear_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 83;
        send_text("Q");
        send_text("P");
        send_text("P5 1 1 255 ");
        send_text("P6");
        send_text("P6 0 7 255\n");
        send_text("P6 2 2 255 ");
        send_text("P6 a 1 255 ");
        send_text("P6 1 -1 255 ");
        send_text("P6 1 1 256 ");
        send_text("P6 1 1 x ");
        send_text("P6 65536 1 255 ");
        send_text("P6 1 999999 255 ");
        send_text("P6 3 2 25");
        send_text("P6 1 1 255");
        send_text("P6xyz\t65535 0 0255\t");
        send_text("P6 1#c\r\n1 1 255 ");
        send_text("P6 2#c\n 1 255 ");
        send_text("P6\n#c\r\n\n1 1 255 ");
        // width token hits the length cap; the next digit is dropped
        add_text("P6 7");
        repeat (TOKEN_LIMIT - 2) add_byte(8'h61);
        send_text("9 1 255 ");
        add_text("P6 1 2 255\n");
        add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80);
        add_byte(8'h7F); add_byte(8'h01); add_byte(8'hFE);
        push_file();
        add_text("P6 12ab 1 255 ");
        repeat (36) add_byte(8'($urandom_range(0, 255)));
        send_text("zz");
        settle();

        write_order(1'b1);
        queue_random_files(500);
        settle();

        write_order(1'b0);
        send_idle_pct = 83;
        recv_idle_pct = 9;
        queue_random_files(500);
        settle();

        write_order(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_files(225);
        settle();

        write_order(1'b0);
        queue_random_files(225);
        settle();

        $display("Run covered %0d files (%0d bytes) under both channel orders",
                 files_taken, bytes_taken);
        $display("Beats checked: %0d pixel, %0d header, %0d error (codes seen %b)",
                 pixels_seen, headers_seen, errors_seen, err_codes_seen[5:0]);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
